// ===== src/brfc_pkg.sv =====
// Shared constants and types for the button ramped fan controller.
// No dependencies; compiled first.
`default_nettype none

package brfc_pkg;

    // Duty accumulator format: unsigned Q8.FRAC_BITS
    localparam int FRAC_BITS  = 16;
    localparam int DUTY_W     = 8;
    localparam int ACC_W      = DUTY_W + FRAC_BITS;
    localparam int RATE_W     = 24;
    localparam int ELAPSED_W  = 8;
    localparam int STEP_W     = RATE_W + ELAPSED_W;
    localparam int SUM_W      = STEP_W + 1;
    localparam int CNT_W      = 8;
    localparam int STATE_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_RATE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_DIVIDER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_THRESHOLD  = 3'd4;

    // Configuration reset values
    localparam logic [DUTY_W-1:0] MIN_DUTY_RST     = 8'd112;
    localparam logic [RATE_W-1:0] RAMP_RATE_RST    = 24'd1114;
    localparam logic [CNT_W-1:0]  SCAN_DIVIDER_RST = 8'd25;
    localparam logic [CNT_W-1:0]  CLICK_THRESH_RST = 8'd4;
    localparam logic [CNT_W-1:0]  LONG_THRESH_RST  = 8'd20;

    localparam logic [CNT_W-1:0]  HOLD_MAX = '1;
    localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

    // Button press states
    typedef enum logic [STATE_W-1:0] {
        PS_IDLE        = 3'd0,
        PS_CLICK       = 3'd1,
        PS_CLICK_REL   = 3'd2,
        PS_LONG        = 3'd3,
        PS_PRESS_REL   = 3'd4
    } press_state_t;

endpackage

`default_nettype wire

// ===== src/brfc_if.sv =====
// Valid/ready channel interfaces: tick input, status output, config write.
// Depends on brfc_pkg.
`default_nettype none

interface brfc_tick_if;
    import brfc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 button_level;
    logic [ELAPSED_W-1:0] elapsed_ms;

    modport source (output valid, output button_level, output elapsed_ms, input ready);
    modport sink   (input valid, input button_level, input elapsed_ms, output ready);
endinterface

interface brfc_status_if;
    import brfc_pkg::*;
    logic               valid;
    logic               ready;
    logic [DUTY_W-1:0]  duty;
    logic               fan_on;
    logic [STATE_W-1:0] button_state;
    logic               ramp_up;

    modport source (output valid, output duty, output fan_on, output button_state,
                    output ramp_up, input ready);
    modport sink   (input valid, input duty, input fan_on, input button_state,
                    input ramp_up, output ready);
endinterface

interface brfc_cfg_if;
    import brfc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/button_ramped_fan_controller.sv =====
// Button ramped fan controller: ticks reach status through stages 1 and 2.
// One tick per cycle unless status stalls; stage 1 registers the ramp step product,
// stage 2 updates scan/press/fan state, and the state registers are the status.
// Reset (rst_n, async low): config to defaults, counters 0, state idle,
// direction up, fan off, duty 0, pipeline empty. Config writes always accepted.
// Depends on brfc_pkg and brfc_if.
`default_nettype none

module button_ramped_fan_controller (
    input  logic                clk,
    input  logic                rst_n,
    brfc_tick_if.sink           tick,
    brfc_status_if.source       status,
    brfc_cfg_if.sink            cfg
);
    import brfc_pkg::*;

    localparam logic [ACC_W-1:0] ACC_TOP = {DUTY_MAX, {FRAC_BITS{1'b0}}};

    // Configuration registers
    logic [DUTY_W-1:0] min_duty_reg;
    logic [RATE_W-1:0] ramp_rate_reg;
    logic [CNT_W-1:0]  scan_divider_reg;
    logic [CNT_W-1:0]  click_thresh_reg;
    logic [CNT_W-1:0]  long_thresh_reg;

    // Stage 1: tick with precomputed step
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_level_reg;
    logic [STEP_W-1:0] s1_step_reg;

    // Stage 2: controller state, also the status payload
    logic              out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]  scan_count_reg, scan_count_next;
    logic [CNT_W-1:0]  hold_count_reg, hold_count_next;
    press_state_t      press_state_reg, press_state_next;
    logic              direction_reg, direction_next;
    logic              running_reg, running_next;
    logic [ACC_W-1:0]  duty_acc_reg, duty_acc_next;

    logic              out_free;
    logic              advance;
    logic              tick_xfer;
    logic [CNT_W-1:0]  scan_inc;
    logic              scan_hit;
    logic [CNT_W-1:0]  hold_inc;
    logic              dir_after_scan;
    logic [ACC_W-1:0]  floor_acc;
    logic [SUM_W-1:0]  up_sum;
    logic [SUM_W-1:0]  down_diff;
    logic [ACC_W-1:0]  ramp_acc;

    // Handshake
    assign out_free   = !out_valid_reg || status.ready;
    assign advance    = s1_valid_reg && out_free;
    assign tick.ready = !s1_valid_reg || out_free;
    assign tick_xfer  = tick.valid && tick.ready;
    assign cfg.ready  = 1'b1;

    assign s1_valid_next  = tick_xfer ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (status.ready ? 1'b0 : out_valid_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_duty_reg     <= MIN_DUTY_RST;
            ramp_rate_reg    <= RAMP_RATE_RST;
            scan_divider_reg <= SCAN_DIVIDER_RST;
            click_thresh_reg <= CLICK_THRESH_RST;
            long_thresh_reg  <= LONG_THRESH_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_MIN_DUTY:        min_duty_reg     <= cfg.data[DUTY_W-1:0];
                CFG_RAMP_RATE:       ramp_rate_reg    <= cfg.data[RATE_W-1:0];
                CFG_SCAN_DIVIDER:    scan_divider_reg <= cfg.data[CNT_W-1:0];
                CFG_CLICK_THRESHOLD: click_thresh_reg <= cfg.data[CNT_W-1:0];
                CFG_LONG_THRESHOLD:  long_thresh_reg  <= cfg.data[CNT_W-1:0];
                default:             ;
            endcase
        end
    end

    // Stage 1 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Stage 1 payload: ramp step = rate * elapsed
    always_ff @(posedge clk)
    begin
        if (tick_xfer)
        begin
            s1_level_reg <= tick.button_level;
            s1_step_reg  <= STEP_W'(ramp_rate_reg) * STEP_W'(tick.elapsed_ms);
        end
    end

    // Scan divider and saturating hold increment
    assign scan_inc = scan_count_reg + 1'b1;
    assign scan_hit = (scan_inc == scan_divider_reg);
    assign scan_count_next = scan_hit ? '0 : scan_inc;
    assign hold_inc = (hold_count_reg == HOLD_MAX) ? hold_count_reg : hold_count_reg + 1'b1;

    // Press state next-state logic
    always_comb
    begin
        press_state_next = press_state_reg;
        hold_count_next  = hold_count_reg;
        dir_after_scan   = direction_reg;
        if (scan_hit)
        begin
            if (s1_level_reg)
            begin
                hold_count_next = hold_inc;
                priority if (hold_inc >= click_thresh_reg && hold_inc < long_thresh_reg)
                    press_state_next = PS_CLICK;
                else if (hold_inc >= long_thresh_reg)
                    press_state_next = PS_LONG;
                else
                    press_state_next = press_state_reg;
            end
            else
            begin
                unique case (press_state_reg)
                    PS_CLICK:
                    begin
                        press_state_next = PS_CLICK_REL;
                        hold_count_next  = '0;
                    end
                    PS_CLICK_REL:
                    begin
                        press_state_next = PS_IDLE;
                        hold_count_next  = '0;
                    end
                    PS_LONG:
                    begin
                        press_state_next = PS_PRESS_REL;
                        hold_count_next  = '0;
                    end
                    PS_PRESS_REL:
                    begin
                        press_state_next = PS_IDLE;
                        dir_after_scan   = !direction_reg;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Ramp arithmetic: saturate at full scale going up, at min_duty going down
    assign floor_acc = {min_duty_reg, {FRAC_BITS{1'b0}}};
    assign up_sum    = SUM_W'(duty_acc_reg) + SUM_W'(s1_step_reg);
    assign down_diff = SUM_W'(duty_acc_reg) - SUM_W'(s1_step_reg);

    always_comb
    begin
        if (direction_reg)
        begin
            ramp_acc = (up_sum >= SUM_W'(ACC_TOP)) ? ACC_TOP : up_sum[ACC_W-1:0];
        end
        else
        begin
            // top bit set means the step exceeds the accumulator
            ramp_acc = (down_diff[SUM_W-1] || down_diff[ACC_W-1:0] < floor_acc)
                       ? floor_acc : down_diff[ACC_W-1:0];
        end
    end

    // Fan outputs driven by the new press state
    always_comb
    begin
        running_next   = running_reg;
        duty_acc_next  = duty_acc_reg;
        direction_next = dir_after_scan;
        unique case (press_state_next)
            PS_LONG:
            begin
                if (running_reg)
                    duty_acc_next = ramp_acc;
            end
            PS_CLICK_REL:
            begin
                if (running_reg)
                begin
                    running_next  = 1'b0;
                    duty_acc_next = '0;
                end
                else
                begin
                    running_next   = 1'b1;
                    direction_next = 1'b1;
                    duty_acc_next  = floor_acc;
                end
            end
            default: ;
        endcase
    end

    // Stage 2 state, updated once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            scan_count_reg  <= '0;
            hold_count_reg  <= '0;
            press_state_reg <= PS_IDLE;
            direction_reg   <= 1'b1;
            running_reg     <= 1'b0;
            duty_acc_reg    <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                scan_count_reg  <= scan_count_next;
                hold_count_reg  <= hold_count_next;
                press_state_reg <= press_state_next;
                direction_reg   <= direction_next;
                running_reg     <= running_next;
                duty_acc_reg    <= duty_acc_next;
            end
        end
    end

    // Status holds while stalled since state only moves on advance
    assign status.valid        = out_valid_reg;
    assign status.duty         = duty_acc_reg[ACC_W-1:FRAC_BITS];
    assign status.fan_on       = running_reg;
    assign status.button_state = press_state_reg;
    assign status.ramp_up      = direction_reg;

    // Checks
    a_off_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> duty_acc_reg == '0)
        else $error("duty nonzero with fan off");

    a_acc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        duty_acc_reg <= ACC_TOP)
        else $error("duty accumulator above full scale");

    a_advance_valid: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced item did not produce a status");

    a_state_on_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !scan_hit) |=> $stable(press_state_reg) && $stable(hold_count_reg))
        else $error("press state moved without a scan");

    a_no_move_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(duty_acc_reg) && $stable(running_reg))
        else $error("fan state moved without an item");

endmodule

`default_nettype wire

// ===== bench/fan_status_checker.sv =====
// Status checker for the button ramped fan controller: watches tick, status and config
// transfers, predicts every status transfer and compares it field by field.
// Depends on brfc_pkg and the channel interfaces in brfc_if.
module fan_status_checker
    import brfc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    brfc_tick_if    tick,
    brfc_status_if  status,
    brfc_cfg_if     cfg,
    output int      failures,
    output int      outstanding
);

    typedef struct packed {
        logic [DUTY_W-1:0]  duty;
        logic               fan_on;
        logic [STATE_W-1:0] button_state;
        logic               ramp_up;
    } fan_status_t;

    // Register copies
    logic [DUTY_W-1:0] min_duty;
    logic [RATE_W-1:0] ramp_rate;
    logic [CNT_W-1:0]  scan_divider;
    logic [CNT_W-1:0]  click_level;
    logic [CNT_W-1:0]  long_level;

    // Controller state
    logic [CNT_W-1:0]  scan_cnt;
    logic [CNT_W-1:0]  hold_cnt;
    press_state_t      press;
    logic              dir_up;
    logic              running;
    logic [ACC_W-1:0]  duty_acc;

    fan_status_t       status_q[$];

    // Advance the controller by one tick and return the new status
    function automatic fan_status_t next_status(input logic level,
                                                input logic [ELAPSED_W-1:0] elapsed);
        logic [SUM_W-1:0] step;
        logic [SUM_W-1:0] acc;
        logic [SUM_W-1:0] top;
        logic [SUM_W-1:0] floor_v;
        fan_status_t      s;

        // Button scan, one in every scan_divider ticks (counter wraps at 256)
        scan_cnt = scan_cnt + 1'b1;
        if (scan_cnt == scan_divider)
        begin
            scan_cnt = '0;
            if (level)
            begin
                if (hold_cnt != HOLD_MAX)
                    hold_cnt = hold_cnt + 1'b1;
                if (hold_cnt >= click_level && hold_cnt < long_level)
                    press = PS_CLICK;
                else if (hold_cnt >= long_level)
                    press = PS_LONG;
            end
            else
            begin
                case (press)
                    PS_CLICK:
                    begin
                        press    = PS_CLICK_REL;
                        hold_cnt = '0;
                    end
                    PS_CLICK_REL:
                    begin
                        press    = PS_IDLE;
                        hold_cnt = '0;
                    end
                    PS_LONG:
                    begin
                        press    = PS_PRESS_REL;
                        hold_cnt = '0;
                    end
                    PS_PRESS_REL:
                    begin
                        press  = PS_IDLE;
                        dir_up = ~dir_up;
                    end
                    default: ;
                endcase
            end
        end

        // Ramp while long pressed, toggle the fan on the click-release tick
        if (press == PS_LONG)
        begin
            if (running)
            begin
                step    = SUM_W'(ramp_rate) * SUM_W'(elapsed);
                top     = SUM_W'(DUTY_MAX) << FRAC_BITS;
                floor_v = SUM_W'(min_duty) << FRAC_BITS;
                acc     = SUM_W'(duty_acc);
                if (dir_up)
                begin
                    acc = acc + step;
                    if (acc >= top)
                        acc = top;
                end
                else if (step > acc || acc - step < floor_v)
                    acc = floor_v;
                else
                    acc = acc - step;
                duty_acc = acc[ACC_W-1:0];
            end
        end
        else if (press == PS_CLICK_REL)
        begin
            if (running)
            begin
                running  = 1'b0;
                duty_acc = '0;
            end
            else
            begin
                running  = 1'b1;
                dir_up   = 1'b1;
                duty_acc = ACC_W'(min_duty) << FRAC_BITS;
            end
        end

        s.duty         = duty_acc[ACC_W-1 -: DUTY_W];
        s.fan_on       = running;
        s.button_state = press;
        s.ramp_up      = dir_up;
        return s;
    endfunction

    // Watch all three channels; compare first so a result never meets its own tick
    always @(posedge clk or negedge rst_n)
    begin
        fan_status_t want;
        if (!rst_n)
        begin
            min_duty     = MIN_DUTY_RST;
            ramp_rate    = RAMP_RATE_RST;
            scan_divider = SCAN_DIVIDER_RST;
            click_level  = CLICK_THRESH_RST;
            long_level   = LONG_THRESH_RST;
            scan_cnt     = '0;
            hold_cnt     = '0;
            press        = PS_IDLE;
            dir_up       = 1'b1;
            running      = 1'b0;
            duty_acc     = '0;
            status_q.delete();
            failures     = 0;
            outstanding  = 0;
        end
        else
        begin
            if (status.valid && status.ready)
            begin
                if (status_q.size() == 0)
                begin
                    $display("%0t: status transfer with none expected (duty %0d fan %0b state %0d up %0b)",
                             $time, status.duty, status.fan_on, status.button_state,
                             status.ramp_up);
                    failures = failures + 1;
                end
                else
                begin
                    want = status_q.pop_front();
                    if (status.duty !== want.duty)
                    begin
                        $display("%0t: duty expected %0d, got %0d", $time, want.duty, status.duty);
                        failures = failures + 1;
                    end
                    if (status.fan_on !== want.fan_on)
                    begin
                        $display("%0t: fan_on expected %0b, got %0b",
                                 $time, want.fan_on, status.fan_on);
                        failures = failures + 1;
                    end
                    if (status.button_state !== want.button_state)
                    begin
                        $display("%0t: button_state expected %0d, got %0d",
                                 $time, want.button_state, status.button_state);
                        failures = failures + 1;
                    end
                    if (status.ramp_up !== want.ramp_up)
                    begin
                        $display("%0t: ramp_up expected %0b, got %0b",
                                 $time, want.ramp_up, status.ramp_up);
                        failures = failures + 1;
                    end
                end
            end

            // Register writes; only the low byte counts for the 8-bit ones
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_MIN_DUTY:        min_duty     = cfg.data[DUTY_W-1:0];
                    CFG_RAMP_RATE:       ramp_rate    = cfg.data[RATE_W-1:0];
                    CFG_SCAN_DIVIDER:    scan_divider = cfg.data[CNT_W-1:0];
                    CFG_CLICK_THRESHOLD: click_level  = cfg.data[CNT_W-1:0];
                    CFG_LONG_THRESHOLD:  long_level   = cfg.data[CNT_W-1:0];
                    default: ;
                endcase
            end

            if (tick.valid && tick.ready)
                status_q.push_back(next_status(tick.button_level, tick.elapsed_ms));

            outstanding = status_q.size();
        end
    end

endmodule

// ===== bench/button_ramped_fan_controller_test.sv =====
// Top of the fan controller bench: clock, reset, tick and config stimulus, status stalls
// and the verdict. Depends on brfc_pkg, brfc_if, the controller and fan_status_checker.
module button_ramped_fan_controller_test;
    import brfc_pkg::*;

    // Index with no register behind it; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   steady = 1'b0;     // no idling on either side while set
    int   ticks_sent = 0;
    int   failures;
    int   outstanding;

    // Settings in force, used to size button gestures
    logic [CNT_W-1:0] cur_div;
    logic [CNT_W-1:0] cur_click;
    logic [CNT_W-1:0] cur_long;

    brfc_tick_if   tick_ch();
    brfc_status_if status_ch();
    brfc_cfg_if    cfg_ch();

    button_ramped_fan_controller dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .status (status_ch),
        .cfg    (cfg_ch)
    );

    fan_status_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick_ch),
        .status      (status_ch),
        .cfg         (cfg_ch),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always #6 clk = ~clk;

    // Status stalls: ready drops about ten percent of the time
    always @(negedge clk)
        status_ch.ready <= steady || ($urandom_range(99) >= 10);

    // Watchdog
    initial
    begin
        #(12 * 200000);
        $display("FAILED: results differ");
        $finish;
    end

    // Elapsed time per tick: mostly short, with the extremes now and then
    function automatic logic [ELAPSED_W-1:0] pick_elapsed();
        int k;
        k = $urandom_range(99);
        if (k < 70)
            return ELAPSED_W'($urandom_range(0, 15));
        else if (k < 80)
            return '1;
        else if (k < 85)
            return '0;
        return ELAPSED_W'($urandom_range(0, 255));
    endfunction

    // One tick transfer, with random idle cycles ahead of it
    task automatic send_tick(input logic level, input logic [ELAPSED_W-1:0] elapsed);
        while (!steady && $urandom_range(99) < 10)
        begin
            tick_ch.valid <= 1'b0;
            @(negedge clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.button_level <= level;
        tick_ch.elapsed_ms   <= elapsed;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        @(negedge clk);
        ticks_sent++;
    endtask

    // Drain outstanding status, then write every register (junk in unused upper bits)
    task automatic apply_settings(input logic [DUTY_W-1:0] md, input logic [RATE_W-1:0] rate,
                                  input logic [CNT_W-1:0] div, input logic [CNT_W-1:0] click,
                                  input logic [CNT_W-1:0] lng);
        logic [CFG_IDX_W-1:0]  idx [6];
        logic [CFG_DATA_W-1:0] val [6];
        tick_ch.valid <= 1'b0;
        cur_div   = div;
        cur_click = click;
        cur_long  = lng;
        idx = '{CFG_MIN_DUTY, CFG_RAMP_RATE, CFG_SCAN_DIVIDER, CFG_CLICK_THRESHOLD,
                CFG_LONG_THRESHOLD, CFG_SPARE};
        val = '{{16'($urandom), md}, rate, {16'($urandom), div}, {16'($urandom), click},
                {16'($urandom), lng}, CFG_DATA_W'($urandom)};
        while (outstanding != 0)
            @(negedge clk);
        for (int i = 0; i < 6; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // One button gesture: a hold sized to the thresholds and a release, or plain noise
    task automatic gesture();
        int eff;
        int hold_scans;
        int rel_scans;
        eff = (cur_div == 0) ? 256 : cur_div;
        if ($urandom_range(99) < 12)
        begin
            repeat ($urandom_range(1, 2 * eff))
                send_tick(1'($urandom_range(1)), pick_elapsed());
        end
        else
        begin
            case ($urandom_range(2))
                0:       hold_scans = $urandom_range(1, cur_click + 1);
                1:       hold_scans = cur_click;
                default: hold_scans = cur_long + $urandom_range(0, (eff > 8) ? 1 : 20);
            endcase
            rel_scans = $urandom_range(1, 3);
            repeat (hold_scans * eff)
                send_tick(1'b1, pick_elapsed());
            repeat (rel_scans * eff)
                send_tick(1'b0, pick_elapsed());
        end
    endtask

    task automatic run_ticks(input int count);
        int target;
        target = ticks_sent + count;
        while (ticks_sent < target)
            gesture();
    endtask

    // Main sequence
    initial
    begin
        logic [RATE_W-1:0] rate;
        tick_ch.valid        = 1'b0;
        tick_ch.button_level = 1'b0;
        tick_ch.elapsed_ms   = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_MIN_DUTY;
        cfg_ch.data          = '0;
        status_ch.ready      = 1'b0;
        cur_div              = SCAN_DIVIDER_RST;
        cur_click            = CLICK_THRESH_RST;
        cur_long             = LONG_THRESH_RST;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed: scan every tick, click at one hold, long press at three
        apply_settings(8'd200, '1, 8'd1, 8'd1, 8'd3);
        send_tick(1'b0, 8'd0);
        // click turns the fan on at min_duty
        send_tick(1'b1, 8'd1);
        send_tick(1'b0, 8'd1);
        send_tick(1'b0, 8'd1);
        // long press, zero elapsed then ramp up into the 255 ceiling
        repeat (3) send_tick(1'b1, 8'd0);
        send_tick(1'b1, 8'd255);
        // release walks through press-released and flips direction to down
        repeat (2) send_tick(1'b0, 8'd255);
        // ramp down with a step bigger than the accumulator lands on min_duty
        repeat (3) send_tick(1'b1, 8'd0);
        send_tick(1'b1, 8'd255);
        repeat (2) send_tick(1'b0, 8'd0);
        // click turns the fan off, then a long press on a stopped fan
        send_tick(1'b1, 8'd7);
        repeat (2) send_tick(1'b0, 8'd7);
        repeat (4) send_tick(1'b1, 8'd255);
        repeat (2) send_tick(1'b0, 8'd255);

        // Slow ramp, ordinary thresholds
        apply_settings(8'd112, 24'd44560, 8'd1, 8'd2, 8'd5);
        run_ticks(100);

        // Zero min_duty, full rate, no idling anywhere
        apply_settings(8'd0, '1, 8'd2, 8'd1, 8'd3);
        steady = 1'b1;
        run_ticks(100);
        steady = 1'b0;

        // Crossed thresholds: long press wins, click never entered
        apply_settings(8'd255, 24'h00FF00, 8'd3, 8'd5, 8'd3);
        run_ticks(120);

        // Highest thresholds: hold counter saturates
        apply_settings(8'd37, 24'd3000, 8'd1, 8'd254, 8'd255);
        run_ticks(100);

        // Divider lowered below the running scan count: count wraps first
        apply_settings(8'd90, 24'd20000, 8'd200, 8'd1, 8'd2);
        repeat (40) send_tick(1'($urandom_range(1)), pick_elapsed());
        apply_settings(8'd90, 24'd0, 8'd10, 8'd1, 8'd2);
        run_ticks(100);

        // Divider zero: one scan every 256 ticks, button held across it
        apply_settings(8'd128, 24'd500000, 8'd0, 8'd1, 8'd2);
        repeat (300) send_tick(1'b1, pick_elapsed());

        // Random settings, small divider
        repeat (4)
        begin
            case ($urandom_range(2))
                0:       rate = RATE_W'($urandom_range(0, 4095));
                1:       rate = RATE_W'($urandom);
                default: rate = RATE_W'($urandom_range(0, 255)) << 8;
            endcase
            apply_settings(DUTY_W'($urandom), rate, CNT_W'($urandom_range(1, 4)),
                           CNT_W'($urandom_range(0, 6)), CNT_W'($urandom_range(0, 8)));
            run_ticks(50);
        end

        // Drain and decide
        tick_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
        if (failures == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
src/brfc_pkg.sv
src/brfc_if.sv
src/button_ramped_fan_controller.sv
bench/fan_status_checker.sv
bench/button_ramped_fan_controller_test.sv
